FILE: hdl/hhc_pkg.sv
// Shared types, constants and helper functions of the HSV/HSL to RGB converter.
`timescale 1ns / 1ps

package hhc_pkg;

  localparam int NUM_STAGES = 8;

  localparam logic [6:0]  PCT_MAX   = 7'd100;
  localparam logic [6:0]  PCT_HALF  = 7'd50;
  localparam logic [8:0]  HUE_WRAP  = 9'd360;
  localparam logic [8:0]  DEG_60    = 9'd60;
  localparam logic [8:0]  DEG_120   = 9'd120;
  localparam logic [8:0]  DEG_180   = 9'd180;
  localparam logic [8:0]  DEG_240   = 9'd240;
  localparam logic [8:0]  DEG_300   = 9'd300;
  localparam logic [7:0]  FULL_8    = 8'd255;
  localparam logic [9:0]  F_MUL     = 10'd17;
  localparam logic [24:0] PCT8_MUL  = 25'd167127;
  localparam logic [23:0] HUE8_MUL  = 24'd46427;
  localparam logic [25:0] DIV255_MUL = 26'd257;
  localparam logic [28:0] DIV43_MUL = 29'd24386;
  localparam logic [7:0]  RED_OFS   = 8'd85;
  localparam logic [7:0]  BLUE_OFS  = 8'd171;
  localparam logic [7:0]  RISE_END  = 8'd43;
  localparam logic [7:0]  HIGH_END  = 8'd128;
  localparam logic [7:0]  FALL_END  = 8'd171;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_e;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  typedef struct packed {
    logic        mode;
    logic        grey;
    logic        llow;
    sector_e     sector;
    logic [7:0]  f;
    logic [7:0]  h8;
    logic [7:0]  s8;
    logic [7:0]  l8;
    logic [15:0] pm;
    logic [16:0] tql;
    logic [15:0] ls;
  } front_t;

  typedef struct packed {
    logic            mode;
    logic            grey;
    logic            llow;
    sector_e         sector;
    logic [7:0]      v8;
    logic [7:0]      p_hsv;
    logic [7:0]      q_hsv;
    logic [7:0]      t_hsv;
    logic [7:0]      p_low;
    logic [7:0]      qh;
    logic [2:0][7:0] tc;
  } mix_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  // clamp to 100 percent, then scale to 0..255 by reciprocal multiply
  function automatic logic [7:0] pct_to_8(input logic [6:0] raw);
    logic [6:0]  pct;
    logic [24:0] prod;
    pct  = (raw > PCT_MAX) ? PCT_MAX : raw;
    prod = 25'(pct) * PCT8_MUL;
    return prod[23:16];
  endfunction

  // exact floor(x / 255) for any 16-bit x
  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [25:0] prod;
    prod = (26'(x) + 26'd1) * DIV255_MUL;
    return prod[24:16];
  endfunction

endpackage

FILE: hdl/hhc_front.sv
// Front stages: input clamping, hue reduction, sector split and first products.
`timescale 1ns / 1ps

module hhc_front (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           command_i,
  input  logic [8:0]     hue_i,
  input  logic [6:0]     saturation_i,
  input  logic [6:0]     level_i,
  output hhc_pkg::front_t front_o
);
  import hhc_pkg::*;

  logic       mode_q;
  logic       grey_q;
  logic       llow_q;
  logic [8:0] hm_d;
  logic [8:0] hm_q;
  logic [7:0] s8_q;
  logic [7:0] l8_q;

  sector_e     sector;
  logic [8:0]  base;
  logic [5:0]  rem;
  logic [9:0]  f17;
  logic [23:0] hprod;
  front_t      front_d;
  front_t      front_q;

  assign hm_d = (hue_i >= HUE_WRAP) ? (hue_i - HUE_WRAP) : hue_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q <= command_i;
      grey_q <= (saturation_i == 7'd0);
      llow_q <= (level_i < PCT_HALF);
      hm_q   <= hm_d;
      s8_q   <= pct_to_8(saturation_i);
      l8_q   <= pct_to_8(level_i);
    end
  end

  always_comb begin
    if (hm_q < DEG_60) begin
      sector = SEC_RED_YEL;
      base   = 9'd0;
    end else if (hm_q < DEG_120) begin
      sector = SEC_YEL_GRN;
      base   = DEG_60;
    end else if (hm_q < DEG_180) begin
      sector = SEC_GRN_CYN;
      base   = DEG_120;
    end else if (hm_q < DEG_240) begin
      sector = SEC_CYN_BLU;
      base   = DEG_180;
    end else if (hm_q < DEG_300) begin
      sector = SEC_BLU_MAG;
      base   = DEG_240;
    end else begin
      sector = SEC_MAG_RED;
      base   = DEG_300;
    end
  end

  assign rem   = 6'(hm_q - base);
  assign f17   = 10'(rem) * F_MUL;
  assign hprod = 24'(hm_q) * HUE8_MUL;

  always_comb begin
    front_d        = '0;
    front_d.mode   = mode_q;
    front_d.grey   = grey_q;
    front_d.llow   = llow_q;
    front_d.sector = sector;
    front_d.f      = f17[9:2];
    front_d.h8     = hprod[23:16];
    front_d.s8     = s8_q;
    front_d.l8     = l8_q;
    front_d.pm     = 16'(l8_q) * 16'(FULL_8 - s8_q);
    front_d.tql    = 17'(l8_q) * (17'(s8_q) + 17'(FULL_8));
    front_d.ls     = 16'(l8_q) * 16'(s8_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

FILE: hdl/hhc_mix.sv
// Middle stages: HSV products, HSL q numerator and the divisions by 255.
`timescale 1ns / 1ps

module hhc_mix (
  input  logic             clk_i,
  input  logic             en_i,
  input  hhc_pkg::front_t  front_i,
  output hhc_pkg::mix_t    mix_o
);
  import hhc_pkg::*;

  typedef struct packed {
    logic            mode;
    logic            grey;
    logic            llow;
    sector_e         sector;
    logic [7:0]      v8;
    logic [7:0]      p_hsv;
    logic [7:0]      p_low;
    logic [15:0]     qm;
    logic [15:0]     tm;
    logic [15:0]     tq;
    logic [2:0][7:0] tc;
  } mid_t;

  mid_t       mid_d;
  mid_t       mid_q;
  logic [8:0] p_hsv_w;
  logic [8:0] p_low_w;
  logic [8:0] q_hsv_w;
  logic [8:0] t_hsv_w;
  logic [8:0] qh_w;
  mix_t       mix_d;
  mix_t       mix_q;

  assign p_hsv_w = div255(front_i.pm);
  assign p_low_w = div255({front_i.pm[14:0], 1'b0});

  always_comb begin
    mid_d                = '0;
    mid_d.mode           = front_i.mode;
    mid_d.grey           = front_i.grey;
    mid_d.llow           = front_i.llow;
    mid_d.sector         = front_i.sector;
    mid_d.v8             = front_i.l8;
    mid_d.p_hsv          = p_hsv_w[7:0];
    mid_d.p_low          = p_low_w[7:0];
    mid_d.qm             = 16'(front_i.l8) * 16'(FULL_8 - front_i.f);
    mid_d.tm             = 16'(front_i.l8) * 16'(front_i.f);
    mid_d.tq             = front_i.llow ? front_i.tql[15:0]
                         : 16'((16'(front_i.l8) + 16'(front_i.s8)) * 16'(FULL_8)) - front_i.ls;
    mid_d.tc[CH_RED]     = front_i.h8 + RED_OFS;
    mid_d.tc[CH_GREEN]   = front_i.h8;
    mid_d.tc[CH_BLUE]    = front_i.h8 + BLUE_OFS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign q_hsv_w = div255(mid_q.qm);
  assign t_hsv_w = div255(mid_q.tm);
  assign qh_w    = div255(mid_q.tq);

  always_comb begin
    mix_d        = '0;
    mix_d.mode   = mid_q.mode;
    mix_d.grey   = mid_q.grey;
    mix_d.llow   = mid_q.llow;
    mix_d.sector = mid_q.sector;
    mix_d.v8     = mid_q.v8;
    mix_d.p_hsv  = mid_q.p_hsv;
    mix_d.q_hsv  = q_hsv_w[7:0];
    mix_d.t_hsv  = t_hsv_w[7:0];
    mix_d.p_low  = mid_q.p_low;
    mix_d.qh     = qh_w[7:0];
    mix_d.tc     = mid_q.tc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

FILE: hdl/hhc_ramp.sv
// Back stages: HSV channel select, HSL hue ramp per channel and output register.
`timescale 1ns / 1ps

module hhc_ramp (
  input  logic            clk_i,
  input  logic            en_i,
  input  hhc_pkg::mix_t   mix_i,
  output hhc_pkg::color_t color_o
);
  import hhc_pkg::*;

  typedef struct packed {
    logic            mode;
    logic            grey;
    logic [7:0]      v8;
    logic [7:0]      p;
    logic [7:0]      q;
    logic            neg;
    logic [2:0][7:0] hsv;
  } ctl_t;

  ctl_t            ctl_d;
  ctl_t            ctl_e_q;
  ctl_t            ctl_f_q;
  ctl_t            ctl_g_q;
  logic [7:0]      p_hsl;
  logic [7:0]      adiff_d;
  logic [7:0]      adiff_q;
  seg_e            seg_d   [3];
  seg_e            seg_e_q [3];
  seg_e            seg_f_q [3];
  seg_e            seg_g_q [3];
  logic [5:0]      m_d     [3];
  logic [5:0]      m_q     [3];
  logic [13:0]     prod_q  [3];
  logic [7:0]      quo_d   [3];
  logic [7:0]      quo_q   [3];
  logic [28:0]     qprod   [3];
  logic [2:0][7:0] ramp_w;
  color_t          color_d;
  color_t          color_q;

  always_comb begin
    if (mix_i.llow) begin
      p_hsl = mix_i.p_low;
    end else if (mix_i.v8[7]) begin
      p_hsl = {mix_i.v8[6:0], 1'b0} - mix_i.qh;
    end else begin
      p_hsl = 8'd0;
    end
  end

  always_comb begin
    ctl_d      = '0;
    ctl_d.mode = mix_i.mode;
    ctl_d.grey = mix_i.grey;
    ctl_d.v8   = mix_i.v8;
    ctl_d.p    = p_hsl;
    ctl_d.q    = mix_i.qh;
    ctl_d.neg  = (mix_i.qh < p_hsl);
    adiff_d    = ctl_d.neg ? (p_hsl - mix_i.qh) : (mix_i.qh - p_hsl);
    case (mix_i.sector)
      SEC_RED_YEL: ctl_d.hsv = {mix_i.p_hsv, mix_i.t_hsv, mix_i.v8};
      SEC_YEL_GRN: ctl_d.hsv = {mix_i.p_hsv, mix_i.v8, mix_i.q_hsv};
      SEC_GRN_CYN: ctl_d.hsv = {mix_i.t_hsv, mix_i.v8, mix_i.p_hsv};
      SEC_CYN_BLU: ctl_d.hsv = {mix_i.v8, mix_i.q_hsv, mix_i.p_hsv};
      SEC_BLU_MAG: ctl_d.hsv = {mix_i.v8, mix_i.p_hsv, mix_i.t_hsv};
      default:     ctl_d.hsv = {mix_i.q_hsv, mix_i.p_hsv, mix_i.v8};
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (mix_i.tc[c] < RISE_END) begin
        seg_d[c] = SEG_RISE;
        m_d[c]   = mix_i.tc[c][5:0];
      end else if (mix_i.tc[c] < HIGH_END) begin
        seg_d[c] = SEG_HIGH;
        m_d[c]   = 6'd0;
      end else if (mix_i.tc[c] < FALL_END) begin
        seg_d[c] = SEG_FALL;
        m_d[c]   = 6'(FALL_END - mix_i.tc[c]);
      end else begin
        seg_d[c] = SEG_LOW;
        m_d[c]   = 6'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_e_q <= ctl_d;
      adiff_q <= adiff_d;
      ctl_f_q <= ctl_e_q;
      ctl_g_q <= ctl_f_q;
      for (int c = 0; c < 3; c++) begin
        seg_e_q[c] <= seg_d[c];
        m_q[c]     <= m_d[c];
        seg_f_q[c] <= seg_e_q[c];
        prod_q[c]  <= 14'(adiff_q) * 14'(m_q[c]);
        seg_g_q[c] <= seg_f_q[c];
        quo_q[c]   <= quo_d[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qprod[c] = 29'(prod_q[c]) * DIV43_MUL;
      quo_d[c] = qprod[c][27:20];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (seg_g_q[c])
        SEG_RISE, SEG_FALL: ramp_w[c] = ctl_g_q.neg ? (ctl_g_q.p - quo_q[c])
                                                    : (ctl_g_q.p + quo_q[c]);
        SEG_HIGH:           ramp_w[c] = ctl_g_q.q;
        default:            ramp_w[c] = ctl_g_q.p;
      endcase
    end
    if (ctl_g_q.grey) begin
      color_d = '{r: ctl_g_q.v8, g: ctl_g_q.v8, b: ctl_g_q.v8};
    end else if (ctl_g_q.mode) begin
      color_d = '{r: ramp_w[CH_RED], g: ramp_w[CH_GREEN], b: ramp_w[CH_BLUE]};
    end else begin
      color_d = '{r: ctl_g_q.hsv[CH_RED], g: ctl_g_q.hsv[CH_GREEN],
                  b: ctl_g_q.hsv[CH_BLUE]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      color_q <= color_d;
    end
  end

  assign color_o = color_q;

endmodule

FILE: hdl/hsv_hsl_to_rgb_converter_core.sv
// Top level of the HSV/HSL to RGB converter: valid pipeline and stall control.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_stall_o | command_i hue_i saturation_i level_i
//  out     | output    | out_valid_o/out_stall_i | red_o green_o blue_o grb_word_o
//
//  One transaction per cycle in, one per cycle out while the output is not stalled;
//  each transaction passes through every register stage of the 8-stage pipeline.
//  Reset clears the stage valid bits only; payload registers are not reset.
//  A stall on a valid output freezes every stage and stalls the input in the same cycle.
//  Bubbles move through without holding any transaction back.
`timescale 1ns / 1ps

module hsv_hsl_to_rgb_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [8:0]  hue_i,
  input  logic [6:0]  saturation_i,
  input  logic [6:0]  level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [23:0] grb_word_o
);
  import hhc_pkg::*;

  logic                  adv;
  logic [NUM_STAGES-1:0] vld_d;
  logic [NUM_STAGES-1:0] vld_q;
  front_t                front;
  mix_t                  mix;
  color_t                color;

  assign adv        = !(vld_q[NUM_STAGES-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign vld_d      = {vld_q[NUM_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  hhc_front u_front (
    .clk_i        (clk_i),
    .en_i         (adv),
    .command_i    (command_i),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .level_i      (level_i),
    .front_o      (front)
  );

  hhc_mix u_mix (
    .clk_i   (clk_i),
    .en_i    (adv),
    .front_i (front),
    .mix_o   (mix)
  );

  hhc_ramp u_ramp (
    .clk_i   (clk_i),
    .en_i    (adv),
    .mix_i   (mix),
    .color_o (color)
  );

  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign red_o       = color.r;
  assign green_o     = color.g;
  assign blue_o      = color.b;
  assign grb_word_o  = {color.g, color.r, color.b};

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> vld_q[0] == $past(in_valid_i))
    else $error("accepted transaction did not enter the first stage");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> vld_q[NUM_STAGES-1] == $past(vld_q[NUM_STAGES-2]))
    else $error("transaction lost or repeated at the output stage");

endmodule
